>>> hw/rtl/ibwt_pkg.sv
// Package for the inverse BWT run expander: actions, status codes, sizes
// and the randomizer table. No dependencies.
package ibwt_pkg;
	localparam int unsigned BLOCK_DEPTH = 1048576;
	localparam int unsigned AW = $clog2(BLOCK_DEPTH);
	localparam int unsigned LW = AW + 1;

	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_BEGIN   = 2'd1,
		ACT_ADVANCE = 2'd2,
		ACT_FINISH  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_ORIGIN = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  data_byte;
		logic [19:0] origin_index;
		logic        randomized;
	} in_item_t;

	typedef struct packed {
		logic [7:0] run_byte;
		logic [8:0] run_length;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	localparam logic [9:0] RND_START = 10'd617;

	function automatic logic [9:0] rnd_entry(input logic [8:0] idx);
		int t [0:511];
		t = '{
		619,720,127,481,931,816,813,233,566,247,985,724,205,454,863,491,
		741,242,949,214,733,859,335,708,621,574,73,654,730,472,419,436,
		278,496,867,210,399,680,480,51,878,465,811,169,869,675,611,697,
		867,561,862,687,507,283,482,129,807,591,733,623,150,238,59,379,
		684,877,625,169,643,105,170,607,520,932,727,476,693,425,174,647,
		73,122,335,530,442,853,695,249,445,515,909,545,703,919,874,474,
		882,500,594,612,641,801,220,162,819,984,589,513,495,799,161,604,
		958,533,221,400,386,867,600,782,382,596,414,171,516,375,682,485,
		911,276,98,553,163,354,666,933,424,341,533,870,227,730,475,186,
		263,647,537,686,600,224,469,68,770,919,190,373,294,822,808,206,
		184,943,795,384,383,461,404,758,839,887,715,67,618,276,204,918,
		873,777,604,560,951,160,578,722,79,804,96,409,713,940,652,934,
		970,447,318,353,859,672,112,785,645,863,803,350,139,93,354,99,
		820,908,609,772,154,274,580,184,79,626,630,742,653,282,762,623,
		680,81,927,626,789,125,411,521,938,300,821,78,343,175,128,250,
		170,774,972,275,999,639,495,78,352,126,857,956,358,619,580,124,
		737,594,701,612,669,112,134,694,363,992,809,743,168,974,944,375,
		748,52,600,747,642,182,862,81,344,805,988,739,511,655,814,334,
		249,515,897,955,664,981,649,113,974,459,893,228,433,837,553,268,
		926,240,102,654,459,51,686,754,806,760,493,403,415,394,687,700,
		946,670,656,610,738,392,760,799,887,653,978,321,576,617,626,502,
		894,679,243,440,680,879,194,572,640,724,926,56,204,700,707,151,
		457,449,797,195,791,558,945,679,297,59,87,824,713,663,412,693,
		342,606,134,108,571,364,631,212,174,643,304,329,343,97,430,751,
		497,314,983,374,822,928,140,206,73,263,980,736,876,478,430,305,
		170,514,364,692,829,82,855,953,676,246,369,970,294,750,807,827,
		150,790,288,923,804,378,215,828,592,281,565,555,710,82,896,831,
		547,261,524,462,293,465,502,56,661,821,976,991,658,869,905,758,
		745,193,768,550,608,933,378,286,215,979,792,961,61,688,793,644,
		986,403,106,366,905,644,372,567,466,434,645,210,389,550,919,135,
		780,773,635,389,707,100,626,958,165,504,920,176,193,713,857,265,
		203,50,668,108,645,990,626,197,510,357,358,850,858,364,936,638};
		return 10'(t[idx]);
	endfunction
endpackage

>>> hw/rtl/ibwt_if.sv
// Valid/ready channel interfaces for items, results and configuration.
// Depends on ibwt_pkg.
interface ibwt_in_if import ibwt_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ibwt_out_if import ibwt_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ibwt_cfg_if;
	logic        valid;
	logic        ready;
	logic [20:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> hw/rtl/inverse_bwt_run_expander.sv
// Top level of the inverse BWT run expander: sequencer, block and link RAMs,
// histogram, randomizer. Depends on ibwt_pkg, ibwt_if, ibwt_ram, ibwt_run_decoder.
//
//  channel | dir | payload
//  in      | in  | action, data_byte, origin_index, randomized
//  out     | out | run_byte, run_length, status, last
//  cfg     | in  | block_limit (21 bits)
//
// Busy states after an item is taken, before in.ready returns: load S_LOAD_RD and
// S_LOAD_WR; advance S_ADV_LINK, S_ADV_BYTE, S_ADV_DONE (link RAM read then block
// RAM read), plus S_OUT when a result goes out. Finish: S_OUT, then a clear sweep
// of all 256 histogram entries. Begin: prefix ranks over the 256 entries, then link
// build per stored byte. Reset is asynchronous; counts reset by the clear sweep
// after reset (in.ready low). A stalled result holds the sequencer.
module inverse_bwt_run_expander import ibwt_pkg::*; (
	input logic clk,
	input logic arst_n,
	ibwt_in_if.sink    in,
	ibwt_out_if.source out,
	ibwt_cfg_if.sink   cfg
);
	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR, S_RANK_RD, S_RANK_WR,
		S_BUILD_RD, S_BUILD_CNT, S_BUILD_WR, S_ADV_LINK, S_ADV_BYTE, S_ADV_DONE,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [20:0] rank;
		logic [20:0] count;
	} hist_t;

	state_t      state_q;
	in_item_t    item_q;
	out_item_t   res_q;
	logic [20:0] limit_q;
	logic [LW-1:0] len_q;
	logic [LW-1:0] idx_q;
	logic [LW-1:0] total_q;
	logic [AW-1:0] walk_q;
	logic [7:0]  hidx_q;
	logic [9:0]  rcd_q;
	logic [8:0]  rpos_q;
	logic        ren_q;
	logic [7:0]  sym_q;
	logic [9:0]  rnd_rd_q;

	// histogram / rank memory
	hist_t       cnt_mem [256];
	hist_t       cnt_rd_q;
	logic        cnt_we;
	logic [7:0]  cnt_addr;
	hist_t       cnt_wd;

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_addr] <= cnt_wd;
		cnt_rd_q <= cnt_mem[cnt_addr];
	end

	always_ff @(posedge clk) begin
		rnd_rd_q <= rnd_entry(rpos_q);
	end

	logic          blk_we, lnk_we;
	logic [AW-1:0] blk_addr, lnk_addr;
	logic [7:0]    blk_rd;
	logic [AW-1:0] lnk_rd, lnk_wd;

	ibwt_ram #(.WIDTH(8), .DEPTH(BLOCK_DEPTH)) u_blk (
		.clk(clk), .we(blk_we), .addr(blk_addr), .wdata(item_q.data_byte), .rdata(blk_rd));
	ibwt_ram #(.WIDTH(AW), .DEPTH(BLOCK_DEPTH)) u_lnk (
		.clk(clk), .we(lnk_we), .addr(lnk_addr), .wdata(lnk_wd), .rdata(lnk_rd));

	logic [LW-1:0] lim_eff;
	assign lim_eff = (limit_q > 21'(BLOCK_DEPTH)) ? LW'(BLOCK_DEPTH) : LW'(limit_q);

	logic       flip;
	logic [7:0] adv_ch;
	assign flip = ren_q && (rcd_q == 10'd0);
	assign adv_ch = blk_rd ^ {7'd0, flip};

	logic       rd_feed, rd_flush, rd_emit;
	logic [7:0] rd_byte;
	logic [8:0] rd_len;
	logic       begin_ok;

	assign rd_feed = (state_q == S_ADV_DONE);
	assign rd_flush = (state_q == S_IDLE) && in.valid &&
		(action_t'(in.data.action) == ACT_FINISH);
	assign begin_ok = (state_q == S_IDLE) && in.valid &&
		(action_t'(in.data.action) == ACT_BEGIN) && (LW'(in.data.origin_index) < len_q);

	ibwt_run_decoder u_run (
		.clk(clk), .arst_n(arst_n), .feed(rd_feed), .ch(adv_ch), .flush(rd_flush),
		.clear(begin_ok), .emit(rd_emit), .emit_byte(rd_byte), .emit_len(rd_len));

	assign in.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign out.valid = (state_q == S_OUT);
	assign out.data = res_q;

	always_comb begin
		cnt_we = 1'b0;
		cnt_addr = hidx_q;
		cnt_wd = '0;
		blk_we = 1'b0;
		blk_addr = idx_q[AW-1:0];
		lnk_we = 1'b0;
		lnk_addr = walk_q;
		lnk_wd = idx_q[AW-1:0];
		case (state_q)
			S_CLEAR: cnt_we = 1'b1;
			S_IDLE: cnt_addr = in.data.data_byte;
			S_LOAD_RD: begin
				cnt_addr = item_q.data_byte;
				blk_addr = len_q[AW-1:0];
				blk_we = 1'b1;
			end
			S_LOAD_WR: begin
				cnt_addr = item_q.data_byte;
				cnt_we = 1'b1;
				cnt_wd = '{cnt_rd_q.rank, cnt_rd_q.count + 21'd1};
			end
			S_RANK_WR: begin
				cnt_we = 1'b1;
				cnt_wd = '{21'(total_q), cnt_rd_q.count};
			end
			S_BUILD_CNT: cnt_addr = blk_rd;
			S_BUILD_WR: begin
				cnt_addr = sym_q;
				cnt_we = 1'b1;
				cnt_wd = '{cnt_rd_q.rank + 21'd1, cnt_rd_q.count};
				lnk_we = (cnt_rd_q.rank < 21'(BLOCK_DEPTH));
				lnk_addr = cnt_rd_q.rank[AW-1:0];
			end
			S_ADV_BYTE: blk_addr = lnk_rd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			item_q <= '0;
			res_q <= '0;
			limit_q <= 21'd900000;
			len_q <= '0;
			idx_q <= '0;
			total_q <= '0;
			walk_q <= '0;
			hidx_q <= '0;
			rcd_q <= RND_START;
			rpos_q <= 9'd1;
			ren_q <= 1'b0;
			sym_q <= '0;
		end else begin
			if (cfg.valid) limit_q <= cfg.data;
			case (state_q)
				S_CLEAR: begin
					if (hidx_q == 8'd255) begin
						hidx_q <= '0;
						state_q <= S_IDLE;
					end else hidx_q <= hidx_q + 8'd1;
				end
				S_IDLE: if (in.valid) begin
					item_q <= in.data;
					case (action_t'(in.data.action))
						ACT_LOAD: begin
							if (len_q >= lim_eff) begin
								res_q <= '{8'd0, 9'd0, ST_FULL, 1'b0};
								state_q <= S_OUT;
							end else state_q <= S_LOAD_RD;
						end
						ACT_BEGIN: begin
							if (!begin_ok) begin
								res_q <= '{8'd0, 9'd0, ST_ORIGIN, 1'b0};
								state_q <= S_OUT;
							end else begin
								hidx_q <= '0;
								total_q <= '0;
								walk_q <= in.data.origin_index[AW-1:0];
								rcd_q <= RND_START;
								rpos_q <= 9'd1;
								ren_q <= in.data.randomized;
								state_q <= S_RANK_RD;
							end
						end
						ACT_ADVANCE: state_q <= S_ADV_LINK;
						default: begin
							res_q <= '{rd_byte, rd_len, ST_OK, 1'b1};
							len_q <= '0;
							walk_q <= '0;
							rcd_q <= RND_START;
							rpos_q <= 9'd1;
							ren_q <= 1'b0;
							hidx_q <= '0;
							state_q <= S_OUT;
						end
					endcase
				end
				S_LOAD_RD: state_q <= S_LOAD_WR;
				S_LOAD_WR: begin
					len_q <= len_q + LW'(1);
					state_q <= S_IDLE;
				end
				S_RANK_RD: state_q <= S_RANK_WR;
				S_RANK_WR: begin
					total_q <= total_q + LW'(cnt_rd_q.count);
					hidx_q <= hidx_q + 8'd1;
					if (hidx_q == 8'd255) begin
						idx_q <= '0;
						state_q <= S_BUILD_RD;
					end else state_q <= S_RANK_RD;
				end
				S_BUILD_RD: state_q <= (idx_q < len_q) ? S_BUILD_CNT : S_IDLE;
				S_BUILD_CNT: begin
					sym_q <= blk_rd;
					state_q <= S_BUILD_WR;
				end
				S_BUILD_WR: begin
					idx_q <= idx_q + LW'(1);
					state_q <= S_BUILD_RD;
				end
				S_ADV_LINK: state_q <= S_ADV_BYTE;
				S_ADV_BYTE: begin
					walk_q <= lnk_rd;
					state_q <= S_ADV_DONE;
				end
				S_ADV_DONE: begin
					if (ren_q) begin
						if (rcd_q == 10'd0) begin
							rcd_q <= rnd_rd_q - 10'd1;
							rpos_q <= rpos_q + 9'd1;
						end else rcd_q <= rcd_q - 10'd1;
					end
					if (rd_emit) begin
						res_q <= '{rd_byte, rd_len, ST_OK, 1'b0};
						state_q <= S_OUT;
					end else state_q <= S_IDLE;
				end
				S_OUT: if (out.ready) state_q <= (res_q.last) ? S_CLEAR : S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// finish result must leave before the clear sweep; sweep index holds at zero
	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && !out.ready |=> out.valid && $stable(out.data))
		else $error("result changed while stalled");
	assert property (@(posedge clk) disable iff (!arst_n)
		in.valid && in.ready |=> !in.ready)
		else $error("item taken twice");
	assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.data.status != ST_OK |-> out.data.run_length == 9'd0)
		else $error("error result with length");
endmodule

>>> hw/rtl/ibwt_ram.sv
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module ibwt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

>>> hw/rtl/ibwt_run_decoder.sv
// Run decoder: four equal bytes then a count byte; flush on finish.
// Depends on ibwt_pkg.
module ibwt_run_decoder import ibwt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       feed,
	input  logic [7:0] ch,
	input  logic       flush,
	input  logic       clear,
	output logic       emit,
	output logic [7:0] emit_byte,
	output logic [8:0] emit_len
);
	logic [7:0] char_q;
	logic [2:0] count_q;

	always_comb begin
		emit = 1'b0;
		emit_byte = '0;
		emit_len = '0;
		if (flush) begin
			emit = 1'b1;
			if (count_q != 3'd0) begin
				emit_byte = char_q;
				emit_len = {6'd0, count_q};
			end
		end else if (feed && count_q != 3'd0 &&
				!(ch == char_q && count_q != 3'd4)) begin
			emit = 1'b1;
			emit_byte = char_q;
			emit_len = (count_q == 3'd4) ? ({1'b0, ch} + 9'd4) : {6'd0, count_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
			count_q <= '0;
		end else if (flush || clear) begin
			char_q <= '0;
			count_q <= '0;
		end else if (feed) begin
			if (count_q == 3'd0) begin
				char_q <= ch;
				count_q <= 3'd1;
			end else if (ch == char_q && count_q != 3'd4) begin
				count_q <= count_q + 3'd1;
			end else if (count_q == 3'd4) begin
				count_q <= 3'd0;
			end else begin
				char_q <= ch;
				count_q <= 3'd1;
			end
		end
	end
endmodule

>>> bench/testbench.sv
// Testbench for inverse_bwt_run_expander: drives load/begin/advance/finish items
// with random stalls, predicts run results in SystemVerilog and checks them.
// Depends on ibwt_pkg, ibwt_if and the RTL top level.
module testbench;
	import ibwt_pkg::*;

	localparam int WATCHDOG = 50000;

	typedef struct {
		action_t     act;
		logic [7:0]  b;
		logic [19:0] org;
		logic        rnd;
		bit          typed;
		out_item_t   res;
	} row_t;

	logic clk;
	logic arst_n;

	ibwt_in_if  in_ch ();
	ibwt_out_if out_ch ();
	ibwt_cfg_if cfg_ch ();

	inverse_bwt_run_expander dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in     (in_ch.sink),
		.out    (out_ch.source),
		.cfg    (cfg_ch.sink)
	);

	logic [7:0]  blk_mem [int unsigned];
	logic [19:0] lnk_mem [int unsigned];
	int unsigned sym_cnt [256];
	int unsigned blk_len;
	logic [19:0] walk_ptr;
	logic [7:0]  cur_char;
	int unsigned cur_count;
	logic [9:0]  rnd_cd;
	logic [8:0]  rnd_pos;
	bit          rnd_on;
	int unsigned limit_reg;
	bit          links_built;

	out_item_t pending_runs[$];
	int        err_cnt;
	int        item_cnt;
	bit        idle_on;
	int        quiet_cyc;
	int        out_hold;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic out_item_t mk_run(logic [7:0] b, logic [8:0] l, status_t s, logic lst);
		out_item_t r;
		r.run_byte = b;
		r.run_length = l;
		r.status = s;
		r.last = lst;
		return r;
	endfunction

	task automatic restart_walk(logic [19:0] org, logic rnd);
		walk_ptr = org;
		cur_char = 0;
		cur_count = 0;
		rnd_cd = RND_START;
		rnd_pos = 9'd1;
		rnd_on = rnd;
	endtask

	task automatic predict_runs(in_item_t it, output bit has, output out_item_t res);
		int unsigned rank [256];
		int unsigned total;
		int unsigned lim;
		int unsigned slot;
		logic [19:0] p;
		logic [7:0]  ch;
		has = 0;
		res = '0;
		case (action_t'(it.action))
			ACT_LOAD: begin
				lim = (limit_reg > BLOCK_DEPTH) ? BLOCK_DEPTH : limit_reg;
				if (blk_len >= lim) begin
					has = 1;
					res = mk_run(8'd0, 9'd0, ST_FULL, 1'b0);
				end else begin
					blk_mem[blk_len] = it.data_byte;
					sym_cnt[it.data_byte]++;
					blk_len++;
				end
			end
			ACT_BEGIN: begin
				if (it.origin_index >= blk_len) begin
					has = 1;
					res = mk_run(8'd0, 9'd0, ST_ORIGIN, 1'b0);
				end else begin
					total = 0;
					for (int i = 0; i < 256; i++) begin
						rank[i] = total;
						total += sym_cnt[i];
					end
					for (int unsigned i = 0; i < blk_len; i++) begin
						slot = rank[blk_mem[i]]++;
						lnk_mem[slot] = i[19:0];
					end
					links_built = 1;
					restart_walk(it.origin_index, it.randomized);
				end
			end
			ACT_ADVANCE: begin
				p = lnk_mem[walk_ptr];
				walk_ptr = p;
				ch = blk_mem[p];
				if (rnd_on) begin
					if (rnd_cd == 0) begin
						rnd_cd = rnd_entry(rnd_pos) - 10'd1;
						rnd_pos = rnd_pos + 9'd1;
						ch[0] = ~ch[0];
					end else begin
						rnd_cd--;
					end
				end
				if (cur_count == 0) begin
					cur_char = ch;
					cur_count = 1;
				end else if (ch == cur_char && cur_count != 4) begin
					cur_count++;
				end else if (cur_count == 4) begin
					cur_count = 0;
					has = 1;
					res = mk_run(cur_char, {1'b0, ch} + 9'd4, ST_OK, 1'b0);
				end else begin
					has = 1;
					res = mk_run(cur_char, cur_count[8:0], ST_OK, 1'b0);
					cur_char = ch;
					cur_count = 1;
				end
			end
			default: begin
				has = 1;
				res = mk_run(cur_count != 0 ? cur_char : 8'd0, cur_count[8:0], ST_OK, 1'b1);
				for (int i = 0; i < 256; i++) sym_cnt[i] = 0;
				blk_len = 0;
				restart_walk(20'd0, 1'b0);
			end
		endcase
	endtask

	task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
		bit has;
		out_item_t res;
		if (idle_on && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= it;
		do @(posedge clk); while (!in_ch.ready);
		predict_runs(it, has, res);
		if (typed) pending_runs.push_back(typed_res);
		else if (has) pending_runs.push_back(res);
		item_cnt++;
	endtask

	task automatic send(action_t a, logic [7:0] b, logic [19:0] org, logic rnd);
		in_item_t it;
		it.action = a;
		it.data_byte = b;
		it.origin_index = org;
		it.randomized = rnd;
		send_item(it, 1'b0, '0);
	endtask

	task automatic write_limit(logic [20:0] v);
		in_ch.valid <= 1'b0;
		wait (pending_runs.size() == 0);
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		limit_reg = v;
	endtask

	task automatic run_block(int n, bit rnd, int alph);
		logic [7:0] sym [4];
		int adv;
		for (int i = 0; i < 4; i++) sym[i] = 8'($urandom_range(0, 255));
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send(ACT_LOAD, 8'($urandom_range(0, 255)), 20'($urandom), 1'($urandom));
			else
				send(ACT_LOAD, sym[$urandom_range(0, alph - 1)], 20'($urandom), 1'($urandom));
		end
		if ($urandom_range(0, 5) == 0)
			send(ACT_BEGIN, 8'($urandom), 20'($urandom), 1'($urandom));
		if (blk_len > 0)
			send(ACT_BEGIN, 8'($urandom), 20'($urandom_range(0, blk_len - 1)), rnd);
		else
			send(ACT_BEGIN, 8'($urandom), 20'($urandom), rnd);
		if (links_built) begin
			adv = blk_len + $urandom_range(0, 3);
			if ($urandom_range(0, 7) == 0) adv = $urandom_range(0, blk_len);
			for (int i = 0; i < adv; i++) begin
				if ($urandom_range(0, 40) == 0 && blk_len > 0)
					send(ACT_BEGIN, 8'($urandom), 20'($urandom_range(0, blk_len - 1)),
						1'($urandom));
				else
					send(ACT_ADVANCE, 8'($urandom), 20'($urandom), 1'($urandom));
			end
		end
		if ($urandom_range(0, 9) != 0)
			send(ACT_FINISH, 8'($urandom), 20'($urandom), 1'($urandom));
	endtask

	always @(posedge clk) begin
		if (out_hold > 0) begin
			out_hold <= out_hold - 1;
			out_ch.ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			out_hold <= $urandom_range(0, 8);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		out_item_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_runs.size() == 0) begin
				$error("unexpected result byte %0d length %0d", out_ch.data.run_byte,
					out_ch.data.run_length);
				err_cnt++;
			end else begin
				want = pending_runs.pop_front();
				if (want.run_byte !== out_ch.data.run_byte) begin
					$error("run_byte expected %0d actual %0d", want.run_byte, out_ch.data.run_byte);
					err_cnt++;
				end
				if (want.run_length !== out_ch.data.run_length) begin
					$error("run_length expected %0d actual %0d", want.run_length,
						out_ch.data.run_length);
					err_cnt++;
				end
				if (want.status !== out_ch.data.status) begin
					$error("status expected %0d actual %0d", want.status, out_ch.data.status);
					err_cnt++;
				end
				if (want.last !== out_ch.data.last) begin
					$error("last expected %0d actual %0d", want.last, out_ch.data.last);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
				(cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cyc <= 0;
		end else if (quiet_cyc >= WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cyc <= quiet_cyc + 1;
		end
	end

	initial begin
		row_t rows [24];
		int limits [8];
		int goal;
		in_item_t it;
		limits = '{1048576, 2097151, 0, 1, 7, 20, 300, 900000};
		rows = '{
			'{ACT_FINISH,  8'd0,   20'd0,     1'b0, 1, '{8'd0, 9'd0, ST_OK, 1'b1}},
			'{ACT_BEGIN,   8'd0,   20'd0,     1'b0, 1, '{8'd0, 9'd0, ST_ORIGIN, 1'b0}},
			'{ACT_LOAD,    8'd65,  20'd0,     1'b0, 0, '0},
			'{ACT_LOAD,    8'd65,  20'd0,     1'b1, 0, '0},
			'{ACT_LOAD,    8'd65,  20'd0,     1'b0, 0, '0},
			'{ACT_LOAD,    8'd65,  20'hFFFFF, 1'b0, 0, '0},
			'{ACT_LOAD,    8'd3,   20'd0,     1'b0, 0, '0},
			'{ACT_LOAD,    8'd255, 20'd0,     1'b0, 0, '0},
			'{ACT_LOAD,    8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_LOAD,    8'd65,  20'd0,     1'b0, 0, '0},
			'{ACT_BEGIN,   8'd0,   20'hFFFFF, 1'b1, 1, '{8'd0, 9'd0, ST_ORIGIN, 1'b0}},
			'{ACT_BEGIN,   8'd0,   20'd8,     1'b0, 1, '{8'd0, 9'd0, ST_ORIGIN, 1'b0}},
			'{ACT_BEGIN,   8'd255, 20'd7,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_FINISH,  8'd0,   20'd0,     1'b0, 0, '0},
			'{ACT_ADVANCE, 8'd0,   20'd0,     1'b0, 0, '0}
		};
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		out_ch.ready = 1'b0;
		out_hold = 0;
		quiet_cyc = 0;
		err_cnt = 0;
		item_cnt = 0;
		idle_on = 1;
		blk_len = 0;
		limit_reg = 900000;
		links_built = 0;
		for (int i = 0; i < 256; i++) sym_cnt[i] = 0;
		restart_walk(20'd0, 1'b0);
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		foreach (rows[i]) begin
			it.action = rows[i].act;
			it.data_byte = rows[i].b;
			it.origin_index = rows[i].org;
			it.randomized = rows[i].rnd;
			send_item(it, rows[i].typed, rows[i].res);
		end

		for (int ph = 0; ph < 8; ph++) begin
			write_limit(21'(limits[ph]));
			idle_on = (ph != 7);
			goal = item_cnt + 170;
			if (ph == 0) run_block(650, 1'b1, 2);
			while (item_cnt < goal)
				run_block($urandom_range(0, 6) == 0 ? $urandom_range(25, 60) :
					$urandom_range(1, 24), 1'($urandom), $urandom_range(1, 3));
		end

		in_ch.valid <= 1'b0;
		wait (pending_runs.size() == 0);
		repeat (300) @(posedge clk);
		if (err_cnt == 0 && pending_runs.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end
endmodule
